/* sv/bsmg_pkg.sv */
package bsmg_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned GROUP_W = 16;

    localparam logic STATUS_ACCEPTED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     restart;
    } item_t;

    typedef struct packed {
        logic                status;
        logic [COUNT_W-1:0]  stored_count;
        logic [DATA_W-1:0]   longest_span;
        logic [DATA_W-1:0]   shortest_span;
        logic                spans_valid;
    } result_t;

    // what one cell hands to its neighbors: gt to both sides, val to the right-hand one
    typedef struct packed {
        logic                     gt;
        logic signed [DATA_W-1:0] val;
    } link_t;

endpackage

/* sv/bounded_set_min_max_gap_unit.sv */
// channel    | signals                          | transfer
// -----------+----------------------------------+---------------------------------
// item in    | start, busy, item                | edge with start high, busy low
// result out | done, result                     | edge ending the cycle done is high
// capacity   | capacity_we, capacity_wdata      | edge with capacity_we high
//
// each item passes the insert into the cell chain, one registered level of the
// neighbor-gap and-tree, then the final merge into the result register.
// done is high for one cycle once the result register is loaded; busy stays high
// until that load, so a new item can be taken in the cycle done is shown.
// reset clears count, capacity (to 1), least gap and the pipeline flags; cell
// contents are not cleared. the result side cannot stall.
module bounded_set_min_max_gap_unit
    import bsmg_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  item_t              item,
    output logic               done,
    output result_t            result,
    input  logic               capacity_we,
    input  logic [COUNT_W-1:0] capacity_wdata
);

    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned KW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [COUNT_W-1:0]        capacity_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             cnt_eff;
    logic [DATA_W-1:0]         least_reg;
    logic [DATA_W-1:0]         least_next;
    logic signed [DATA_W-1:0]  max_reg;
    logic                      status_reg;
    logic                      s1_reg;
    logic                      s2_reg;
    logic                      done_reg;
    result_t                   result_reg;
    result_t                   result_next;
    logic                      accept;
    logic                      reject;
    logic                      ins;
    logic [KW-1:0]             limit;
    logic [KW-1:0]             cap_k;
    logic [DATA_W-1:0]         pred_min;
    logic [DATA_W-1:0]         succ_min;
    logic [DATA_W-1:0]         cand_min;

    link_t [MAX_ENTRIES-1:0]              links;
    logic  [MAX_ENTRIES-1:0]              occ;
    logic  [MAX_ENTRIES-1:0][DATA_W-1:0]  pred_gaps;
    logic  [MAX_ENTRIES-1:0][DATA_W-1:0]  succ_gaps;

    assign accept = start && !busy;
    assign busy   = s1_reg || s2_reg;

    // admission check against the effective limit
    assign cnt_eff = item.restart ? '0 : count_reg;
    assign cap_k   = KW'(capacity_reg);
    assign limit   = (cap_k > KW'(MAX_ENTRIES)) ? KW'(MAX_ENTRIES) : cap_k;
    assign reject  = (limit == '0) || (KW'(cnt_eff) >= limit);
    assign ins     = accept && !reject;
    assign count_next = reject ? cnt_eff : cnt_eff + CW'(1);

    // row of sorted cells
    generate
        for (genvar i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            link_t left_l;
            logic  right_gt;

            assign occ[i] = CW'(i) < cnt_eff;

            if (i == 0)
            begin : g_first
                assign left_l = '{gt: 1'b0, val: '0};
            end
            else
            begin : g_mid
                assign left_l = links[i-1];
            end

            if (i == MAX_ENTRIES - 1)
            begin : g_last
                assign right_gt = 1'b1;
            end
            else
            begin : g_inner
                assign right_gt = links[i+1].gt;
            end

            bsmg_cell u_cell (
                .clk      (clk),
                .ins      (ins),
                .x        (item.value),
                .occ      (occ[i]),
                .left     (left_l),
                .right_gt (right_gt),
                .own      (links[i]),
                .pred_gap (pred_gaps[i]),
                .succ_gap (succ_gaps[i])
            );
        end
    endgenerate

    // reduce the neighbor gaps
    bsmg_gap_tree #(.N(MAX_ENTRIES)) u_pred_tree (
        .clk    (clk),
        .leaves (pred_gaps),
        .merged (pred_min)
    );

    bsmg_gap_tree #(.N(MAX_ENTRIES)) u_succ_tree (
        .clk    (clk),
        .leaves (succ_gaps),
        .merged (succ_min)
    );

    assign cand_min   = (pred_min < succ_min) ? pred_min : succ_min;
    assign least_next = (cand_min < least_reg) ? cand_min : least_reg;

    // assemble the result
    always_comb
    begin
        result_next.status        = status_reg;
        result_next.stored_count  = COUNT_W'(count_reg);
        result_next.spans_valid   = count_reg >= CW'(2);
        result_next.longest_span  = '0;
        result_next.shortest_span = '0;
        if (count_reg >= CW'(2))
        begin
            result_next.longest_span  = DATA_W'(max_reg) - DATA_W'(links[0].val);
            result_next.shortest_span = least_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= COUNT_W'(1);
            count_reg    <= '0;
            least_reg    <= '1;
            s1_reg       <= 1'b0;
            s2_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
            s1_reg   <= accept;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg;
            if (accept)
            begin
                count_reg <= count_next;
                if (item.restart)
                begin
                    least_reg <= '1;
                end
            end
            if (s2_reg)
            begin
                least_reg <= least_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= reject ? STATUS_REJECTED : STATUS_ACCEPTED;
        end
        if (ins && ((cnt_eff == '0) || (item.value >= max_reg)))
        begin
            max_reg <= item.value;
        end
        if (s2_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("stored count above capacity of the chain");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##2 done)
        else $error("result not delivered three cycles after the item");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while an item is still in flight");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.spans_valid == (count_reg >= CW'(2))))
        else $error("spans_valid disagrees with the stored count");

endmodule

/* sv/bsmg_cell.sv */
module bsmg_cell
    import bsmg_pkg::*;
(
    input  logic                     clk,
    input  logic                     ins,
    input  logic signed [DATA_W-1:0] x,
    input  logic                     occ,
    input  link_t                    left,
    input  logic                     right_gt,
    output link_t                    own,
    output logic [DATA_W-1:0]        pred_gap,
    output logic [DATA_W-1:0]        succ_gap
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic [DATA_W-1:0]        pred_gap_reg;
    logic [DATA_W-1:0]        pred_gap_next;
    logic [DATA_W-1:0]        succ_gap_reg;
    logic [DATA_W-1:0]        succ_gap_next;
    logic                     gt;
    logic                     is_pred;
    logic                     is_succ;

    // an empty cell counts as larger than any number
    assign gt = !occ || (val_reg > x);

    // shift right where the left neighbor is larger too, else take the new number
    always_comb
    begin
        val_next = val_reg;
        if (gt)
        begin
            val_next = left.gt ? left.val : x;
        end
    end

    // neighbors of the new number in sorted order
    assign is_pred = occ && !gt && right_gt;
    assign is_succ = occ && gt && !left.gt;

    // gap candidates, all ones where this cell is no neighbor
    assign pred_gap_next = (ins && is_pred) ? (DATA_W'(x) - DATA_W'(val_reg)) : '1;
    assign succ_gap_next = (ins && is_succ) ? (DATA_W'(val_reg) - DATA_W'(x)) : '1;

    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            val_reg <= val_next;
        end
        pred_gap_reg <= pred_gap_next;
        succ_gap_reg <= succ_gap_next;
    end

    assign own.gt   = gt;
    assign own.val  = val_reg;
    assign pred_gap = pred_gap_reg;
    assign succ_gap = succ_gap_reg;

endmodule

/* sv/bsmg_gap_tree.sv */
module bsmg_gap_tree
    import bsmg_pkg::*;
#(
    parameter int unsigned N = 256
)
(
    input  logic                       clk,
    input  logic [N-1:0][DATA_W-1:0]   leaves,
    output logic [DATA_W-1:0]          merged
);

    localparam int unsigned NG = (N + GROUP_W - 1) / GROUP_W;

    logic [NG-1:0][DATA_W-1:0] group_reg;
    logic [NG-1:0][DATA_W-1:0] group_next;

    // first level: and of each group of leaves, all-ones leaves drop out
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            group_next[g] = '1;
            for (int k = 0; k < GROUP_W; k++)
            begin
                if (g * GROUP_W + k < N)
                begin
                    group_next[g] = group_next[g] & leaves[g * GROUP_W + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    // second level over the registered groups
    always_comb
    begin
        merged = '1;
        for (int g = 0; g < NG; g++)
        begin
            merged = merged & group_reg[g];
        end
    end

endmodule

/* sim/span_checker.sv */
module span_checker
    import bsmg_pkg::*;
#(
    parameter int unsigned DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  item_t              item,
    input  logic               done,
    input  result_t            result,
    input  logic               capacity_we,
    input  logic [COUNT_W-1:0] capacity_wdata,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int unsigned PRINT_LIMIT = 40;

    // predicted copy of the block state
    logic signed [DATA_W-1:0] held_values[$];
    logic [DATA_W-1:0]        least_gap;
    logic [COUNT_W-1:0]       capacity_copy;

    result_t predicted_results[$];
    int      mismatch_count = 0;

    assign mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
        mismatch_count++;
    endtask

    function automatic void note_gap(input logic signed [DATA_W-1:0] lo,
                                     input logic signed [DATA_W-1:0] hi);
        logic [DATA_W-1:0] gap;
        gap = hi - lo;
        if (gap < least_gap)
            least_gap = gap;
    endfunction

    // insert one number and measure the spans that follow
    function automatic result_t insert_and_measure(input item_t it);
        logic signed [DATA_W-1:0] v;
        int unsigned              limit;
        int                       pos;
        result_t                  r;
        v = it.value;
        r = '0;
        if (it.restart)
        begin
            held_values.delete();
            least_gap = '1;
        end
        limit = 32'(capacity_copy);
        if (limit > DEPTH)
            limit = DEPTH;
        if (limit == 0 || held_values.size() >= limit)
        begin
            r.status = STATUS_REJECTED;
        end
        else
        begin
            r.status = STATUS_ACCEPTED;
            pos = 0;
            while (pos < held_values.size() && held_values[pos] <= v)
                pos++;
            held_values.insert(pos, v);
            if (pos > 0)
                note_gap(held_values[pos-1], v);
            if (pos + 1 < held_values.size())
                note_gap(v, held_values[pos+1]);
        end
        r.stored_count = COUNT_W'(held_values.size());
        if (held_values.size() >= 2)
        begin
            r.longest_span  = held_values[held_values.size()-1] - held_values[0];
            r.shortest_span = least_gap;
            r.spans_valid   = 1'b1;
        end
        return r;
    endfunction

    // watch all channels at the clock edge that accepts them
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            held_values.delete();
            predicted_results.delete();
            least_gap     = '1;
            capacity_copy = COUNT_W'(1);
            outstanding  <= 0;
        end
        else
        begin
            // result transfer, compared before any new item is predicted
            if (done === 1'b1)
            begin
                if (predicted_results.size() == 0)
                begin
                    report_mismatch("unexpected result", '0,
                                    DATA_W'(result.stored_count));
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", DATA_W'(want.status),
                                        DATA_W'(result.status));
                    if (result.stored_count !== want.stored_count)
                        report_mismatch("stored_count", DATA_W'(want.stored_count),
                                        DATA_W'(result.stored_count));
                    if (result.longest_span !== want.longest_span)
                        report_mismatch("longest_span", want.longest_span,
                                        result.longest_span);
                    if (result.shortest_span !== want.shortest_span)
                        report_mismatch("shortest_span", want.shortest_span,
                                        result.shortest_span);
                    if (result.spans_valid !== want.spans_valid)
                        report_mismatch("spans_valid", DATA_W'(want.spans_valid),
                                        DATA_W'(result.spans_valid));
                end
            end
            // item transfer, seen with the capacity held before this edge
            if (start === 1'b1 && busy === 1'b0)
            begin
                fresh = insert_and_measure(item);
                predicted_results = {predicted_results, fresh};
            end
            // capacity register write
            if (capacity_we === 1'b1)
                capacity_copy = capacity_wdata;
            outstanding <= predicted_results.size();
        end
    end

endmodule

/* sim/testbench.sv */
module testbench;
    import bsmg_pkg::*;

    localparam int unsigned DEPTH         = 256;
    localparam int unsigned RANDOM_ITEMS  = 850;
    localparam int unsigned FILL_ITEMS    = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    item_t              item;
    logic               done;
    result_t            result;
    logic               capacity_we;
    logic [COUNT_W-1:0] capacity_wdata;

    int          failures;
    int          pending;
    int unsigned cycles;
    logic        no_idle;

    bounded_set_min_max_gap_unit #(.MAX_ENTRIES(DEPTH)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .done           (done),
        .result         (result),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata)
    );

    span_checker #(.DEPTH(DEPTH)) u_span_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .done           (done),
        .result         (result),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .mismatches     (failures),
        .outstanding    (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    // one item transfer, after a random idle gap
    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic rs);
        int unsigned gap;
        item_t       next;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        next.value   = v;
        next.restart = rs;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= next;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every predicted result has arrived
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [COUNT_W-1:0] cap);
        drain();
        capacity_wdata <= cap;
        capacity_we    <= 1'b1;
        @(posedge clk);
        capacity_we    <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(
        input int unsigned style, input logic signed [DATA_W-1:0] base);
        logic signed [DATA_W-1:0] v;
        case (style)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 40)) - 20;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: v = VALUE_MIN;
                    1: v = VALUE_MIN + 1;
                    2: v = VALUE_MAX;
                    3: v = VALUE_MAX - 1;
                    4: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = base + ($signed($urandom_range(0, 64)) - 32);
        endcase
        return v;
    endfunction

    initial
    begin
        int unsigned              sent;
        int unsigned              phase;
        int unsigned              run_len;
        int unsigned              style;
        logic [COUNT_W-1:0]       cap;
        logic                     rs;
        logic signed [DATA_W-1:0] cluster_base;

        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        capacity_we    = 1'b0;
        capacity_wdata = '0;
        no_idle        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity of one: second number is rejected
        send_item(0, 1'b0);
        send_item(5, 1'b0);
        // zero capacity rejects, restart still empties the store
        set_capacity(COUNT_W'(0));
        send_item(7, 1'b1);
        // capacity above the store size, full-range extremes and equal numbers
        set_capacity(9'h1FF);
        send_item(VALUE_MIN, 1'b1);
        send_item(VALUE_MAX, 1'b0);
        send_item(0, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shAAAA_AAAA, 1'b0);
        // capacity lowered below the count keeps the store and rejects new numbers
        set_capacity(COUNT_W'(3));
        send_item(9, 1'b0);
        send_item(100, 1'b1);
        send_item(50, 1'b0);
        send_item(200, 1'b0);
        send_item(75, 1'b0);
        set_capacity(COUNT_W'(DEPTH));
        send_item(10, 1'b1);
        send_item(10, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_MIN, 1'b0);

        // random phases, one of them filling the whole store
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 2)
            begin
                cap     = COUNT_W'($urandom_range(DEPTH, 511));
                run_len = FILL_ITEMS;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: cap = COUNT_W'(0);
                    1: cap = COUNT_W'(1);
                    2: cap = COUNT_W'(2);
                    3: cap = COUNT_W'($urandom_range(3, 12));
                    4: cap = COUNT_W'($urandom_range(13, 40));
                    default: cap = COUNT_W'($urandom_range(41, 511));
                endcase
                run_len = $urandom_range(10, 40);
            end
            set_capacity(cap);
            no_idle      = ($urandom_range(0, 3) == 0);
            style        = $urandom_range(0, 3);
            cluster_base = $urandom;
            for (int unsigned i = 0; i < run_len; i++)
            begin
                if (phase == 2)
                    rs = (i == 0);
                else if (i == 0)
                    rs = ($urandom_range(0, 3) != 0);
                else
                    rs = ($urandom_range(0, 24) == 0);
                send_item(pick_value(($urandom_range(0, 3) == 0) ? 0 : style, cluster_base),
                          rs);
                sent++;
            end
            phase++;
        end

        drain();
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
